// ----- src/utds_pkg.sv -----
// shared constants and types for the usb transfer descriptor splitter
`timescale 1ns / 1ps
package utds_pkg;

   localparam int AddrWidth     = 16;
   localparam int CountWidth    = 14;
   localparam int MpsWidth      = 11;
   localparam int NumWidth      = 5;
   localparam int CsrIndexWidth = 2;

   localparam logic [NumWidth-1:0]   MaxResults = NumWidth'(20);
   localparam logic [CountWidth-1:0] ChunkSpan  = 14'h2000;

   localparam logic [31:0] SetupControl = 32'hF2E4_0000;
   localparam logic [31:0] CcField      = 32'hF000_0000;
   localparam logic [31:0] ToggleData1  = 32'h0300_0000;
   localparam logic [31:0] DelayNone    = 32'h00E0_0000;
   localparam logic [31:0] RoundBit     = 32'h0004_0000;
   localparam int          PidShift     = 19;

   localparam logic [1:0] PidOut = 2'd1;
   localparam logic [1:0] PidIn  = 2'd2;

   localparam logic [1:0] StageSetup  = 2'd0;
   localparam logic [1:0] StageData   = 2'd1;
   localparam logic [1:0] StageStatus = 2'd2;

   localparam logic [CsrIndexWidth-1:0] CsrSharedBase = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrBounceBase = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrSetupBase  = 2'd2;

   typedef struct packed {
      logic start;
   } rem_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } rem_sts_type;

endpackage

// ----- src/utds_remainder.sv -----
// iterative restoring remainder unit: one shift and subtract per cycle
`timescale 1ns / 1ps
module utds_remainder (
   input  logic                           clock,
   input  logic                           reset,
   input  utds_pkg::rem_ctl_type          ctl,
   input  logic [utds_pkg::CountWidth-1:0] dividend,
   input  logic [utds_pkg::MpsWidth-1:0]   divisor,
   output utds_pkg::rem_sts_type          sts,
   output logic [utds_pkg::MpsWidth-1:0]   remainder
);
   import utds_pkg::*;

   localparam int StepWidth = $clog2(CountWidth + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [StepWidth-1:0]  step_ff, step_in;
   logic [CountWidth-1:0] shift_ff, shift_in;
   logic [MpsWidth-1:0]   divisor_ff, divisor_in;
   logic [MpsWidth-1:0]   rem_ff, rem_in;
   logic [MpsWidth:0]     trial;

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      shift_in   = shift_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      trial      = {rem_ff, shift_ff[CountWidth-1]};
      if (!busy_ff) begin
         if (ctl.start) begin
            busy_in    = 1'b1;
            step_in    = '0;
            shift_in   = dividend;
            divisor_in = divisor;
            rem_in     = '0;
         end
      end else begin
         // partial remainder stays below the divisor, so one subtract is enough
         if (trial >= {1'b0, divisor_ff}) begin
            trial = trial - {1'b0, divisor_ff};
         end
         rem_in   = trial[MpsWidth-1:0];
         shift_in = {shift_ff[CountWidth-2:0], 1'b0};
         step_in  = step_ff + 1'b1;
         if (step_ff == StepWidth'(CountWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      shift_ff   <= shift_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
   end

   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;
   assign remainder = rem_ff;

endmodule

// ----- src/usb_transfer_descriptor_splitter.sv -----
// top level: turns one usb transfer request into its general transfer descriptors
//
// A request is taken when start is high and busy is low. Busy then stays high
// until the last descriptor of that request is registered, and it is low again
// in the cycle that shows it. Each descriptor appears on the rsp_ ports for
// exactly one cycle with rsp_valid high, and rsp_last marks the final one.
// The receiver cannot stall the block.
// A control request emits a setup descriptor, its data descriptors and a status
// descriptor; a bulk request emits only data descriptors, and none for zero
// length (busy then never rises). A request gives at most 20 descriptors in all.
// Steps: a setup or status descriptor is registered straight from its state.
// A data chunk passes through ST_CHUNK and then ST_EMIT, and through ST_DIV
// between them when it must be trimmed to whole packets, since the remainder
// by the max packet size comes from a shift-subtract unit that retires one
// dividend bit a cycle over 14 bits.
// The csr_ port writes the shared base, bounce base and setup packet address
// at any edge with csr_write_enable high; write it only while busy is low.
// Reset is synchronous: it drops busy and rsp_valid and clears the csr registers.
`timescale 1ns / 1ps
module usb_transfer_descriptor_splitter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_mode,
   input  logic [1:0]                        req_direction,
   input  logic                              req_buffer_present,
   input  logic [utds_pkg::AddrWidth-1:0]    req_buffer_address,
   input  logic [15:0]                       req_transfer_length,
   input  logic [utds_pkg::MpsWidth-1:0]     req_max_packet_size,
   output logic                              rsp_valid,
   output logic [31:0]                       rsp_descriptor_control,
   output logic [utds_pkg::AddrWidth-1:0]    rsp_descriptor_buffer_start,
   output logic [utds_pkg::AddrWidth-1:0]    rsp_descriptor_buffer_end,
   output logic [1:0]                        rsp_stage,
   output logic                              rsp_last,
   input  logic                              csr_write_enable,
   input  logic [utds_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [15:0]                       csr_write_data
);
   import utds_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_CHUNK,
      ST_DIV,
      ST_EMIT,
      ST_STATUS
   } state_type;

   state_type             state_ff, state_in;
   logic                  control_ff, control_in;
   logic [1:0]            pid_ff, pid_in;
   logic [AddrWidth-1:0]  ptr_ff, ptr_in;
   logic [15:0]           remain_ff, remain_in;
   logic [MpsWidth-1:0]   mps_ff, mps_in;
   logic [NumWidth-1:0]   num_ff, num_in;
   logic [CountWidth-1:0] count_ff, count_in;

   logic [AddrWidth-1:0]  shared_base_ff, bounce_base_ff, setup_base_ff;

   logic                  out_valid_ff, out_valid_in;
   logic [31:0]           out_control_ff, out_control_in;
   logic [AddrWidth-1:0]  out_start_ff, out_start_in;
   logic [AddrWidth-1:0]  out_end_ff, out_end_in;
   logic [1:0]            out_stage_ff, out_stage_in;
   logic                  out_last_ff, out_last_in;

   rem_ctl_type           rem_ctl;
   rem_sts_type           rem_sts;
   logic [MpsWidth-1:0]   rem_value;

   logic [CountWidth-1:0] chunk_raw;
   logic [15:0]           remain_next;
   logic [NumWidth-1:0]   num_next;
   logic                  data_final;
   logic [31:0]           data_control;
   logic [1:0]            status_pid;

   assign chunk_raw   = ChunkSpan - {2'b00, ptr_ff[11:0]};
   assign remain_next = remain_ff - {2'b00, count_ff};
   assign num_next    = num_ff + 1'b1;
   assign data_final  = (num_next == MaxResults) || ((remain_next == '0) && !control_ff);
   assign status_pid  = (pid_ff == PidIn) ? PidOut : PidIn;

   always_comb begin
      data_control = CcField | DelayNone | (32'(pid_ff) << PidShift);
      if (control_ff) begin
         data_control = data_control | ToggleData1;
      end
      if (remain_next == '0) begin
         data_control = data_control | RoundBit;
      end
      if (data_final) begin
         data_control = data_control & ~DelayNone;
      end
   end

   utds_remainder u_remainder (
      .clock     (clock),
      .reset     (reset),
      .ctl       (rem_ctl),
      .dividend  (chunk_raw),
      .divisor   (mps_ff),
      .sts       (rem_sts),
      .remainder (rem_value)
   );

   always_comb begin
      state_in       = state_ff;
      control_in     = control_ff;
      pid_in         = pid_ff;
      ptr_in         = ptr_ff;
      remain_in      = remain_ff;
      mps_in         = mps_ff;
      num_in         = num_ff;
      count_in       = count_ff;
      out_valid_in   = 1'b0;
      out_control_in = out_control_ff;
      out_start_in   = out_start_ff;
      out_end_in     = out_end_ff;
      out_stage_in   = out_stage_ff;
      out_last_in    = out_last_ff;
      rem_ctl.start  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               control_in = !req_mode;
               pid_in     = (req_direction == PidIn) ? PidIn : PidOut;
               remain_in  = req_transfer_length;
               mps_in     = req_max_packet_size;
               num_in     = '0;
               if (!req_buffer_present) begin
                  ptr_in = '0;
               end else if (req_buffer_address < shared_base_ff) begin
                  ptr_in = bounce_base_ff;
               end else begin
                  ptr_in = req_buffer_address;
               end
               if (!req_mode) begin
                  state_in = ST_SETUP;
               end else if (req_transfer_length != '0) begin
                  state_in = ST_CHUNK;
               end
            end
         end
         ST_SETUP: begin
            out_valid_in   = 1'b1;
            out_control_in = SetupControl;
            out_start_in   = setup_base_ff;
            out_end_in     = setup_base_ff + AddrWidth'(7);
            out_stage_in   = StageSetup;
            out_last_in    = 1'b0;
            num_in         = num_next;
            state_in       = (remain_ff != '0) ? ST_CHUNK : ST_STATUS;
         end
         ST_CHUNK: begin
            if ({2'b00, chunk_raw} < remain_ff) begin
               count_in = chunk_raw;
               if (mps_ff != '0) begin
                  rem_ctl.start = 1'b1;
                  state_in      = ST_DIV;
               end else begin
                  state_in = ST_EMIT;
               end
            end else begin
               // remaining bytes fit in this chunk
               count_in = remain_ff[CountWidth-1:0];
               state_in = ST_EMIT;
            end
         end
         ST_DIV: begin
            if (rem_sts.done) begin
               count_in = count_ff - {3'b000, rem_value};
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            out_valid_in   = 1'b1;
            out_control_in = data_control;
            out_start_in   = ptr_ff;
            out_end_in     = ptr_ff + AddrWidth'(count_ff) - 1'b1;
            out_stage_in   = StageData;
            out_last_in    = data_final;
            ptr_in         = ptr_ff + AddrWidth'(count_ff);
            remain_in      = remain_next;
            num_in         = num_next;
            if (num_next == MaxResults) begin
               state_in = ST_IDLE;
            end else if (remain_next != '0) begin
               state_in = ST_CHUNK;
            end else if (control_ff) begin
               state_in = ST_STATUS;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_STATUS: begin
            out_valid_in   = 1'b1;
            out_control_in = CcField | ToggleData1 | (32'(status_pid) << PidShift);
            out_start_in   = '0;
            out_end_in     = '0;
            out_stage_in   = StageStatus;
            out_last_in    = 1'b1;
            num_in         = num_next;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      control_ff     <= control_in;
      pid_ff         <= pid_in;
      ptr_ff         <= ptr_in;
      remain_ff      <= remain_in;
      mps_ff         <= mps_in;
      num_ff         <= num_in;
      count_ff       <= count_in;
      out_control_ff <= out_control_in;
      out_start_ff   <= out_start_in;
      out_end_ff     <= out_end_in;
      out_stage_ff   <= out_stage_in;
      out_last_ff    <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shared_base_ff <= '0;
         bounce_base_ff <= '0;
         setup_base_ff  <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CsrSharedBase: shared_base_ff <= csr_write_data;
            CsrBounceBase: bounce_base_ff <= csr_write_data;
            CsrSetupBase:  setup_base_ff  <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign busy                        = (state_ff != ST_IDLE);
   assign rsp_valid                   = out_valid_ff;
   assign rsp_descriptor_control      = out_control_ff;
   assign rsp_descriptor_buffer_start = out_start_ff;
   assign rsp_descriptor_buffer_end   = out_end_ff;
   assign rsp_stage                   = out_stage_ff;
   assign rsp_last                    = out_last_ff;

   // a descriptor only comes out of a request in progress
   a_valid_needs_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("descriptor emitted while idle");

   // nothing follows the final descriptor of a request
   a_last_ends_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy ##1 !rsp_valid)
      else $error("descriptor after last");

   // the remainder unit only runs while trimming a chunk
   a_div_in_state: assert property (@(posedge clock) disable iff (reset)
      rem_sts.busy |-> state_ff == ST_DIV)
      else $error("remainder unit busy outside trim");

   // remainder is always below the packet size
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      rem_sts.done |-> rem_value < mps_ff)
      else $error("remainder out of range");

endmodule
